FILE: rtl/smft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smft_pkg;

  localparam int unsigned LengthWidth = 32;
  localparam logic [31:0] MaxSizeReset = 32'd1048576;

  localparam logic [31:0] CodeProto30 = 32'h0003_0000;
  localparam logic [31:0] CodeSsl     = 32'h04D2_162F;
  localparam logic [31:0] CodeGss     = 32'h04D2_1630;
  localparam logic [31:0] CodeCancel  = 32'h04D2_162E;

  localparam logic [1:0] RoleType   = 2'd0;
  localparam logic [1:0] RoleLength = 2'd1;
  localparam logic [1:0] RolePay    = 2'd2;
  localparam logic [1:0] RoleIgnore = 2'd3;

  localparam logic [2:0] KindNone   = 3'd0;
  localparam logic [2:0] KindChar   = 3'd1;
  localparam logic [2:0] KindStrEnd = 3'd2;
  localparam logic [2:0] KindInt    = 3'd3;
  localparam logic [2:0] KindParam  = 3'd4;
  localparam logic [2:0] KindSel    = 3'd5;
  localparam logic [2:0] KindSkip   = 3'd6;
  localparam logic [2:0] KindSpEnd  = 3'd7;

  localparam logic [4:0] ClsUnknown  = 5'd0;
  localparam logic [4:0] ClsStartup  = 5'd1;
  localparam logic [4:0] ClsSsl      = 5'd2;
  localparam logic [4:0] ClsGss      = 5'd3;
  localparam logic [4:0] ClsCancel   = 5'd4;
  localparam logic [4:0] ClsBind     = 5'd5;
  localparam logic [4:0] ClsClose    = 5'd6;
  localparam logic [4:0] ClsCopyFail = 5'd7;
  localparam logic [4:0] ClsDescribe = 5'd8;
  localparam logic [4:0] ClsExecute  = 5'd9;
  localparam logic [4:0] ClsFuncCall = 5'd10;
  localparam logic [4:0] ClsCopyData = 5'd11;
  localparam logic [4:0] ClsParse    = 5'd12;
  localparam logic [4:0] ClsQuery    = 5'd13;
  localparam logic [4:0] ClsPassword = 5'd14;
  localparam logic [4:0] ClsCopyDone = 5'd15;
  localparam logic [4:0] ClsFlush    = 5'd16;
  localparam logic [4:0] ClsSync     = 5'd17;
  localparam logic [4:0] ClsTerminate = 5'd18;

  localparam logic [4:0] LDone   = 5'd0;
  localparam logic [4:0] LCode   = 5'd1;
  localparam logic [4:0] LSpName = 5'd2;
  localparam logic [4:0] LSpVal  = 5'd3;
  localparam logic [4:0] LSpEnd  = 5'd4;
  localparam logic [4:0] LPid    = 5'd5;
  localparam logic [4:0] LKey    = 5'd6;
  localparam logic [4:0] LSel    = 5'd7;
  localparam logic [4:0] LStr1   = 5'd8;
  localparam logic [4:0] LStr2   = 5'd9;
  localparam logic [4:0] LFid    = 5'd10;
  localparam logic [4:0] LFmtN   = 5'd11;
  localparam logic [4:0] LFmt    = 5'd12;
  localparam logic [4:0] LPrmN   = 5'd13;
  localparam logic [4:0] LPlen   = 5'd14;
  localparam logic [4:0] LPdata  = 5'd15;
  localparam logic [4:0] LRslN   = 5'd16;
  localparam logic [4:0] LRsl    = 5'd17;
  localparam logic [4:0] LResFmt = 5'd18;
  localparam logic [4:0] LPtypeN = 5'd19;
  localparam logic [4:0] LPtype  = 5'd20;
  localparam logic [4:0] LRows   = 5'd21;
  localparam logic [4:0] LSkip   = 5'd22;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] tcls;
  } item_t;

  function automatic logic [4:0] type_class(input logic [7:0] b);
    logic [4:0] c;
    case (b)
      8'h42:   c = ClsBind;
      8'h43:   c = ClsClose;
      8'h66:   c = ClsCopyFail;
      8'h44:   c = ClsDescribe;
      8'h45:   c = ClsExecute;
      8'h46:   c = ClsFuncCall;
      8'h64:   c = ClsCopyData;
      8'h50:   c = ClsParse;
      8'h51:   c = ClsQuery;
      8'h70:   c = ClsPassword;
      8'h63:   c = ClsCopyDone;
      8'h48:   c = ClsFlush;
      8'h53:   c = ClsSync;
      8'h58:   c = ClsTerminate;
      default: c = ClsUnknown;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] first_step(input logic [4:0] c);
    logic [4:0] s;
    case (c)
      ClsClose, ClsDescribe:                       s = LSel;
      ClsFuncCall:                                 s = LFid;
      ClsCopyData, ClsPassword:                    s = LSkip;
      ClsCopyDone, ClsFlush, ClsSync, ClsTerminate: s = LDone;
      default:                                     s = LStr1;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] int_bytes(input logic [4:0] s);
    logic [2:0] n;
    case (s)
      LFmtN, LFmt, LPrmN, LRslN, LRsl, LResFmt, LPtypeN: n = 3'd2;
      default:                                          n = 3'd4;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/smft_front.sv
`timescale 1ns / 1ps
`default_nettype none
module smft_front import smft_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  output logic            item_valid_o,
  input  wire logic       item_ready_i,
  output item_t           item_o
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q].data <= data_byte_i;
      mem_q[wptr_q].tcls <= type_class(data_byte_i);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/smft_back.sv
`timescale 1ns / 1ps
`default_nettype none
module smft_back import smft_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        item_valid_i,
  output logic             item_ready_o,
  input  wire item_t       item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       byte_role_o,
  output logic [4:0]       msg_class_o,
  output logic [2:0]       field_kind_o,
  output logic             field_done_o,
  output logic [31:0]      field_value_o,
  output logic             msg_last_o,
  output logic             oversize_o,
  output logic             sync_error_o,
  output logic [7:0]       echo_byte_o
);

  logic [31:0] max_q;
  logic [2:0]  phase_q, phase_d;
  logic        oos_q, oos_d;
  logic [4:0]  cls_q, cls_d;
  logic [31:0] lsh_q, lsh_d;
  logic [31:0] left_q, left_d;
  logic [4:0]  step_q, step_d;
  logic [31:0] ish_q, ish_d;
  logic [1:0]  iseen_q, iseen_d;
  logic [15:0] loop_q, loop_d;
  logic [15:0] pcnt_q, pcnt_d;
  logic [31:0] pleft_q, pleft_d;

  logic        take;
  logic [7:0]  b;
  logic [1:0]  role;
  logic [2:0]  kind;
  logic        done, last, over, err, check, parsed;
  logic [31:0] value, len, ival, pl;
  logic [15:0] pc;
  logic [4:0]  pend;

  assign take         = item_valid_i && (!out_valid_o || out_ready_i);
  assign item_ready_o = !out_valid_o || out_ready_i;
  assign b            = item_i.data;

  always_comb begin
    phase_d = phase_q; oos_d = oos_q; cls_d = cls_q; lsh_d = lsh_q;
    left_d = left_q; step_d = step_q; ish_d = ish_q; iseen_d = iseen_q;
    loop_d = loop_q; pcnt_d = pcnt_q; pleft_d = pleft_q;
    role = RoleType; kind = KindNone; done = 1'b0; value = '0;
    last = 1'b0; over = 1'b0; err = 1'b0; check = 1'b0;
    len = {lsh_q[23:0], b};
    ival = {ish_q[23:0], b};
    pend = (cls_q == ClsBind) ? LRslN : LResFmt;
    parsed = 1'b0; pl = '0; pc = '0;
    if (oos_q) begin
      role = RoleIgnore;
    end else begin
      if (phase_q == 3'd0) begin
        lsh_d = '0;
        if (b == 8'd0) begin
          cls_d = ClsUnknown; step_d = LCode; phase_d = 3'd2; role = RoleLength;
        end else begin
          cls_d = item_i.tcls; step_d = LDone; phase_d = 3'd1;
        end
      end else if (phase_q <= 3'd3) begin
        role = RoleLength;
        lsh_d = len;
        phase_d = phase_q + 3'd1;
      end else if (phase_q == 3'd4) begin
        role = RoleLength;
        if (len < 32'd4 || (len >> (LengthWidth - 1)) != '0) begin
          err = 1'b1;
        end else begin
          left_d = len - 32'd4;
          if (step_q != LCode) begin
            if (cls_q == ClsUnknown) begin
              err = 1'b1;
            end else begin
              step_d = first_step(cls_q);
              parsed = cls_q != ClsCopyData && cls_q != ClsPassword &&
                       cls_q < ClsCopyDone && cls_q >= ClsBind;
              if (parsed && left_d > max_q) step_d = LSkip;
            end
          end
          phase_d = 3'd5;
          check = !err;
        end
      end else begin
        role = RolePay;
        if (left_q != '0) left_d = left_q - 32'd1;
        case (step_q)
          LSkip: kind = KindSkip;
          LSpName, LSpVal, LStr1, LStr2: begin
            kind = (b != 8'd0) ? KindChar : KindStrEnd;
            if (b == 8'd0) begin
              case (step_q)
                LSpName: step_d = LSpVal;
                LSpVal:  step_d = (left_d > 32'd1) ? LSpName : LSpEnd;
                LStr1: begin
                  if (cls_q == ClsBind || cls_q == ClsParse) step_d = LStr2;
                  else if (cls_q == ClsExecute) step_d = LRows;
                  else step_d = LDone;
                end
                default: begin
                  if (cls_q == ClsBind) step_d = LFmtN;
                  else if (cls_q == ClsParse) step_d = LPtypeN;
                  else step_d = LDone;
                end
              endcase
            end
          end
          LSpEnd: begin
            if (b == 8'd0) begin
              kind = KindSpEnd; step_d = LDone;
            end else begin
              err = 1'b1;
            end
          end
          LSel: begin
            kind = KindSel;
            if (b == 8'h53 || b == 8'h50) step_d = LStr2;
            else err = 1'b1;
          end
          LPdata: begin
            kind = KindParam;
            pl = pleft_q - 32'd1;
            pleft_d = pl;
            if (pl == '0) begin
              pc = pcnt_q - 16'd1;
              pcnt_d = pc;
              step_d = (pc != '0) ? LPlen : pend;
            end
          end
          LDone: err = 1'b1;
          default: begin
            kind = KindInt;
            ish_d = ival;
            if (({1'b0, iseen_q} + 3'd1) >= int_bytes(step_q)) begin
              done = 1'b1; value = ival; ish_d = '0; iseen_d = '0;
              case (step_q)
                LCode: begin
                  if (ival == CodeProto30) begin
                    cls_d = ClsStartup;
                    if ({1'b0, left_d} + 33'd4 > {1'b0, max_q}) step_d = LSkip;
                    else step_d = (left_d > 32'd1) ? LSpName : LSpEnd;
                  end else if (ival == CodeSsl) begin
                    cls_d = ClsSsl; step_d = LDone;
                  end else if (ival == CodeGss) begin
                    cls_d = ClsGss; step_d = LDone;
                  end else if (ival == CodeCancel) begin
                    cls_d = ClsCancel; step_d = LPid;
                  end else begin
                    err = 1'b1;
                  end
                end
                LPid: step_d = LKey;
                LFid: step_d = LFmtN;
                LFmtN: begin
                  loop_d = ival[15:0];
                  step_d = (ival[15:0] != '0) ? LFmt : LPrmN;
                end
                LFmt: begin
                  loop_d = loop_q - 16'd1;
                  step_d = (loop_d != '0) ? LFmt : LPrmN;
                end
                LPrmN: begin
                  pcnt_d = ival[15:0];
                  step_d = (ival[15:0] != '0) ? LPlen : pend;
                end
                LPlen: begin
                  if (ival == 32'hFFFF_FFFF || ival == '0) begin
                    pc = pcnt_q - 16'd1;
                    pcnt_d = pc;
                    step_d = (pc != '0) ? LPlen : pend;
                  end else if (ival[31]) begin
                    err = 1'b1;
                  end else begin
                    pleft_d = ival; step_d = LPdata;
                  end
                end
                LRslN, LPtypeN: begin
                  loop_d = ival[15:0];
                  step_d = (ival[15:0] != '0) ? step_q + 5'd1 : LDone;
                end
                LRsl, LPtype: begin
                  loop_d = loop_q - 16'd1;
                  if (loop_d == '0) step_d = LDone;
                end
                default: step_d = LDone;
              endcase
            end else begin
              iseen_d = iseen_q + 2'd1;
            end
          end
        endcase
        check = !err;
      end

      if (check) begin
        if (step_d == LSkip) last = (left_d == '0);
        else if (step_d == LDone) begin
          if (left_d == '0) last = 1'b1;
          else err = 1'b1;
        end else if (left_d == '0) err = 1'b1;
      end
      over = step_d == LSkip && cls_d != ClsCopyData && cls_d != ClsPassword;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxSizeReset;
      oos_q <= 1'b0; phase_q <= '0; cls_q <= '0; lsh_q <= '0; left_q <= '0;
      step_q <= LDone; ish_q <= '0; iseen_q <= '0; loop_q <= '0; pcnt_q <= '0;
      pleft_q <= '0; out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (take) begin
        out_valid_o <= 1'b1;
        if (err || last) begin
          oos_q <= oos_q | err;
          phase_q <= '0; cls_q <= '0; lsh_q <= '0; left_q <= '0; step_q <= LDone;
          ish_q <= '0; iseen_q <= '0; loop_q <= '0; pcnt_q <= '0; pleft_q <= '0;
        end else begin
          oos_q <= oos_d; phase_q <= phase_d; cls_q <= cls_d; lsh_q <= lsh_d;
          left_q <= left_d; step_q <= step_d; ish_q <= ish_d; iseen_q <= iseen_d;
          loop_q <= loop_d; pcnt_q <= pcnt_d; pleft_q <= pleft_d;
        end
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_role_o   <= role;
      msg_class_o   <= oos_q ? ClsUnknown : cls_d;
      field_kind_o  <= kind;
      field_done_o  <= done;
      field_value_o <= value;
      msg_last_o    <= last;
      oversize_o    <= over;
      sync_error_o  <= err;
      echo_byte_o   <= b;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sql_frontend_message_tokenizer.sv
// Labels each byte of the client-to-server stream of the SQL wire protocol.
// Input channel: data_byte_i with in_valid_i / in_ready_o, one byte a request.
// Output channel: one result a byte, with out_valid_o / out_ready_i.
// Configuration: cfg_we_i writes cfg_wdata_i into max_size.
// A byte enters a two-entry queue and is tokenized when the output register
// is free or being emptied; its result is then registered in the output
// register. The throughput is one byte a cycle while the receiver does not
// stall, set by the single tokenizer state update per byte.
// When the receiver stalls, the output register holds its result and the
// queue fills; in_ready_o falls once both queue entries are taken.
// Reset clears the queue, the parse state and the sync error flag, and sets
// max_size to 1048576. After a sync error every byte is reported as ignored
// until the next reset.
`timescale 1ns / 1ps
`default_nettype none
module sql_frontend_message_tokenizer import smft_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       byte_role_o,
  output logic [4:0]       msg_class_o,
  output logic [2:0]       field_kind_o,
  output logic             field_done_o,
  output logic [31:0]      field_value_o,
  output logic             msg_last_o,
  output logic             oversize_o,
  output logic             sync_error_o,
  output logic [7:0]       echo_byte_o
);

  logic  item_valid, item_ready;
  item_t item;

  smft_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i,
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  smft_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o, .out_ready_i, .byte_role_o, .msg_class_o, .field_kind_o,
    .field_done_o, .field_value_o, .msg_last_o, .oversize_o, .sync_error_o,
    .echo_byte_o
  );

  a_ignored_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_role_o == RoleIgnore |->
      field_kind_o == KindNone && !msg_last_o && !sync_error_o && !field_done_o)
    else $error("ignored byte carries token data");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !field_done_o |-> field_value_o == '0)
    else $error("field value without completed integer");

  a_last_or_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(msg_last_o && sync_error_o))
    else $error("message end and sync error together");

endmodule
`default_nettype wire
